// File: design/contiguous_block_bitmap_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cbba_pkg.sv
// Shared constants, codes and controller/datapath types of the allocator.
// Depends on nothing; every other design file but the assertion macros header imports it.
package cbba_pkg;

    // Sizing of the bitmap.
    localparam int TOTAL_BLOCK_COUNT = 1024;
    localparam int BYTES_PER_BLOCK   = 512;

    // Fixed field widths.
    localparam int ACT_W  = 2;
    localparam int SIZE_W = 24;
    localparam int ADDR_W = 25;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int FB_W   = 10;
    localparam int CFG_W  = 24;

    // Derived widths.
    localparam int BLK_W   = $clog2(TOTAL_BLOCK_COUNT);
    localparam int CNT_W   = $clog2(TOTAL_BLOCK_COUNT + 1);
    localparam int WORD_W  = 16;
    localparam int WB_W    = $clog2(WORD_W);
    localparam int NWORDS  = (TOTAL_BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WC_W    = $clog2(NWORDS + 1);
    localparam int GW      = WA_W + WB_W;
    localparam int BPB_W   = $clog2(BYTES_PER_BLOCK + 1);
    localparam int BPB_SH  = $clog2(BYTES_PER_BLOCK);
    localparam int NEED_W  = SIZE_W + 1;
    localparam int PROD_W  = BLK_W + BPB_W;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_step;
        logic              fit_load;
        logic              mark_init;
        logic              mark_rd;
        logic              mark_wr;
        logic              query_rd;
        logic              addr_load;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             need_zero;
        logic             need_big;
        logic             free_bad;
        logic             query_oob;
        logic             scan_hit;
        logic             scan_end;
        logic             mark_last;
    } t_stat;

endpackage

// File: design/cbba_ifs.sv
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on cbba_pkg for the field widths.
interface cbba_req_if;
    import cbba_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [SIZE_W-1:0]   byte_size;
    logic [ADDR_W-1:0]   release_address;
    logic [IDX_W-1:0]    block_index;
    modport source (output valid, action, byte_size, release_address, block_index,
                    input ready);
    modport sink   (input valid, action, byte_size, release_address, block_index,
                    output ready);
endinterface

interface cbba_rsp_if;
    import cbba_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [FB_W-1:0]     first_block;
    logic [ADDR_W-1:0]   first_address;
    logic                block_used;
    modport source (output valid, status, first_block, first_address, block_used,
                    input ready);
    modport sink   (input valid, status, first_block, first_address, block_used,
                    output ready);
endinterface

interface cbba_cfg_if;
    import cbba_pkg::*;
    logic               valid;
    logic               ready;
    logic [CFG_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: design/cbba_ctrl.sv
// Controller state machine of the allocator: sequences the scan and the marking.
// Depends on cbba_pkg and the assertion macros header.
`include "contiguous_block_bitmap_allocator_defines.svh"

module cbba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cbba_pkg::t_cmd o_cmd,
    input  cbba_pkg::t_stat i_stat
);
    import cbba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_FOUND  = 4'd3;
    localparam logic [3:0] S_MINIT  = 4'd4;
    localparam logic [3:0] S_MRD    = 4'd5;
    localparam logic [3:0] S_MWR    = 4'd6;
    localparam logic [3:0] S_ADDR   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next-state and command decode.
    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_status = ST_DONE;
                n_state  = S_FINISH;
                case (i_stat.action)
                    ACT_ALLOC: begin
                        if (i_stat.need_zero) begin
                            n_state = S_ADDR;
                        end else if (i_stat.need_big) begin
                            n_status = ST_NO_SPACE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_FREE: begin
                        if (i_stat.free_bad) begin
                            n_status = ST_RANGE;
                        end else if (!i_stat.need_zero) begin
                            o_cmd.mark_init = 1'b1;
                            n_state         = S_MRD;
                        end
                    end
                    ACT_QUERY: begin
                        if (i_stat.query_oob) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_cmd.query_rd = 1'b1;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = S_FOUND;
                end else if (i_stat.scan_end) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FOUND: begin
                o_cmd.fit_load = 1'b1;
                n_state        = S_MINIT;
            end
            S_MINIT: begin
                o_cmd.mark_init = 1'b1;
                n_state         = S_MRD;
            end
            S_MRD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.mark_wr = 1'b1;
                if (!i_stat.mark_last) begin
                    n_state = S_MRD;
                end else if (i_stat.action == ACT_ALLOC) begin
                    n_state = S_ADDR;
                end else begin
                    n_status = ST_DONE;
                    n_state  = S_FINISH;
                end
            end
            S_ADDR: begin
                o_cmd.addr_load = 1'b1;
                n_status        = ST_DONE;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.res_status = r_status;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register is held until the consumer takes the transaction.
    always_comb begin
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    `CBBA_ASSERT_IMP(a_res_slot_free, i_clk, i_rst_n, o_cmd.res_load,
        !r_out_valid || i_out_ready, "result overwritten before it was taken")
    `CBBA_ASSERT_IMP(a_mark_rmw, i_clk, i_rst_n, o_cmd.mark_wr,
        $past(o_cmd.mark_rd), "bitmap write without a preceding read")
    `CBBA_ASSERT_NXT(a_accept_decide, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_DECIDE, "accepted request did not move to the decision")

endmodule

// File: design/cbba_datapath.sv
// Datapath of the allocator: bitmap memory, block arithmetic, first-fit scan and run marking.
// Depends on cbba_pkg; driven by cbba_ctrl through t_cmd and t_stat.
module cbba_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbba_pkg::t_cmd                i_cmd,
    output cbba_pkg::t_stat               o_stat,
    input  logic                          i_cfg_we,
    input  logic [cbba_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [cbba_pkg::ACT_W-1:0]    i_action,
    input  logic [cbba_pkg::SIZE_W-1:0]   i_byte_size,
    input  logic [cbba_pkg::ADDR_W-1:0]   i_release_address,
    input  logic [cbba_pkg::IDX_W-1:0]    i_block_index,
    output logic [cbba_pkg::STAT_W-1:0]   o_status,
    output logic [cbba_pkg::FB_W-1:0]     o_first_block,
    output logic [cbba_pkg::ADDR_W-1:0]   o_first_address,
    output logic                          o_block_used
);
    import cbba_pkg::*;

    // Configuration and captured request.
    logic [CFG_W-1:0]  r_region_base;
    logic [ACT_W-1:0]  r_action;
    logic [IDX_W-1:0]  r_idx;
    logic              r_below;

    // Block count of the request and start block of a release.
    logic [NEED_W-1:0] r_need;
    logic [ADDR_W-1:0] r_rel_start;

    // Scan state.
    logic [WC_W-1:0]   r_sc_raddr;
    logic              r_sc_pend;
    logic [WA_W-1:0]   r_sc_paddr;
    logic [CNT_W-1:0]  r_run;
    logic              r_hit;
    logic [GW-1:0]     r_hit_g;
    logic [WORD_W-1:0] sc_used;
    logic [CNT_W:0]    sc_len [WORD_W];
    logic              sc_hit;
    logic [WB_W-1:0]   sc_pos;

    // Bitmap memory with a valid bit per row so that reset reads as all free.
    logic [WORD_W-1:0] mem [NWORDS];
    logic [NWORDS-1:0] r_row_vld;
    logic [WORD_W-1:0] r_rdata;
    logic              rd_en;
    logic [WA_W-1:0]   rd_addr;
    logic [WORD_W-1:0] wr_data;

    // Marking state.
    logic [WA_W-1:0]   r_mk_addr, r_mk_last;
    logic [CNT_W-1:0]  r_mk_lo, r_mk_hi;
    logic [WORD_W-1:0] mk_mask;
    logic [31:0]       mk_s32, mk_e32, mk_e1;

    // Result formation.
    logic [BLK_W-1:0]  r_fit_start;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       idx32, fb32;
    logic              res_ok;
    logic [STAT_W-1:0] r_status;
    logic [FB_W-1:0]   r_first_block;
    logic [ADDR_W-1:0] r_first_address;
    logic              r_block_used;

    assign idx32 = 32'(r_idx);
    assign fb32  = 32'(r_fit_start);

    // Run lengths ending at each bit of the word under scan, and the first fit in it.
    always_comb begin
        logic            found;
        logic [WB_W-1:0] lu;
        logic [31:0]     g32;
        for (int b = 0; b < WORD_W; b++) begin
            g32        = 32'({r_sc_paddr, WB_W'(b)});
            sc_used[b] = r_rdata[b] | (g32 >= 32'(TOTAL_BLOCK_COUNT));
        end
        for (int i = 0; i < WORD_W; i++) begin
            found = 1'b0;
            lu    = '0;
            for (int j = 0; j <= i; j++) begin
                if (sc_used[j]) begin
                    found = 1'b1;
                    lu    = WB_W'(j);
                end
            end
            sc_len[i] = found ? ((CNT_W+1)'(i) - (CNT_W+1)'(lu))
                              : ((CNT_W+1)'(r_run) + (CNT_W+1)'(i + 1));
        end
        sc_hit = 1'b0;
        sc_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (32'(sc_len[i]) >= 32'(r_need)) begin
                sc_hit = 1'b1;
                sc_pos = WB_W'(i);
            end
        end
    end

    // Bounds of the run to mark and the bit mask of the current row.
    always_comb begin
        logic [31:0] g32;
        mk_s32 = (r_action == ACT_ALLOC) ? 32'(r_fit_start) : 32'(r_rel_start);
        mk_e32 = mk_s32 + 32'(r_need);
        mk_e1  = mk_e32 - 32'd1;
        for (int b = 0; b < WORD_W; b++) begin
            g32        = 32'({r_mk_addr, WB_W'(b)});
            mk_mask[b] = (g32 >= 32'(r_mk_lo)) && (g32 < 32'(r_mk_hi));
        end
        wr_data = (r_action == ACT_ALLOC) ? (r_rdata | mk_mask) : (r_rdata & ~mk_mask);
    end

    // Memory read port selection.
    always_comb begin
        rd_en = (i_cmd.scan_step && (r_sc_raddr < WC_W'(NWORDS)))
              || i_cmd.mark_rd || i_cmd.query_rd;
        if (i_cmd.mark_rd) begin
            rd_addr = r_mk_addr;
        end else if (i_cmd.query_rd) begin
            rd_addr = idx32[WB_W +: WA_W];
        end else begin
            rd_addr = r_sc_raddr[WA_W-1:0];
        end
    end

    // Bitmap storage.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_row_vld[rd_addr] ? mem[rd_addr] : '0;
        end
        if (i_cmd.mark_wr) begin
            mem[r_mk_addr] <= wr_data;
        end
    end

    // Control state: configuration, row valid bits and scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
            r_row_vld     <= '0;
            r_sc_pend     <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_region_base <= i_cfg_data;
            end
            if (i_cmd.mark_wr) begin
                r_row_vld[r_mk_addr] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_sc_pend <= 1'b0;
                r_hit     <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_sc_pend <= (r_sc_raddr < WC_W'(NWORDS));
                if (r_sc_pend && !r_hit && sc_hit) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // Request capture, scan, marking and result registers.
    // The block size is a power of two, so the block counts are shifts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_idx       <= i_block_index;
            r_below     <= (i_release_address < ADDR_W'(r_region_base));
            r_need      <= (NEED_W'(i_byte_size) + NEED_W'(BYTES_PER_BLOCK - 1)) >> BPB_SH;
            r_rel_start <= (i_release_address - ADDR_W'(r_region_base)) >> BPB_SH;
            r_fit_start <= '0;
        end
        if (i_cmd.scan_start) begin
            r_sc_raddr <= '0;
            r_run      <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_sc_raddr < WC_W'(NWORDS)) begin
                r_sc_raddr <= r_sc_raddr + WC_W'(1);
                r_sc_paddr <= r_sc_raddr[WA_W-1:0];
            end
            if (r_sc_pend && !r_hit) begin
                r_run   <= CNT_W'(sc_len[WORD_W-1]);
                r_hit_g <= {r_sc_paddr, sc_pos};
            end
        end
        if (i_cmd.fit_load) begin
            r_fit_start <= BLK_W'(32'(r_hit_g) + 32'd1 - 32'(r_need));
        end
        if (i_cmd.mark_init) begin
            r_mk_lo   <= CNT_W'(mk_s32);
            r_mk_hi   <= CNT_W'(mk_e32);
            r_mk_addr <= mk_s32[WB_W +: WA_W];
            r_mk_last <= mk_e1[WB_W +: WA_W];
        end else if (i_cmd.mark_wr) begin
            r_mk_addr <= r_mk_addr + WA_W'(1);
        end
        if (i_cmd.addr_load) begin
            r_prod <= PROD_W'(r_fit_start) * PROD_W'(BYTES_PER_BLOCK);
        end
        if (i_cmd.res_load) begin
            r_status        <= i_cmd.res_status;
            r_first_block   <= (res_ok && r_action == ACT_ALLOC) ? fb32[FB_W-1:0] : '0;
            r_first_address <= (res_ok && r_action == ACT_ALLOC)
                             ? ADDR_W'(r_region_base) + ADDR_W'(r_prod) : '0;
            r_block_used    <= (res_ok && r_action == ACT_QUERY)
                             ? r_rdata[idx32[WB_W-1:0]] : 1'b0;
        end
    end

    assign res_ok = (i_cmd.res_status == ST_DONE);

    // Status towards the controller.
    always_comb begin
        o_stat           = '0;
        o_stat.action    = r_action;
        o_stat.need_zero = (r_need == '0);
        o_stat.need_big  = (32'(r_need) > 32'(TOTAL_BLOCK_COUNT));
        o_stat.free_bad  = r_below
                         || ((32'(r_rel_start) + 32'(r_need)) > 32'(TOTAL_BLOCK_COUNT));
        o_stat.query_oob = (idx32 >= 32'(TOTAL_BLOCK_COUNT));
        o_stat.scan_hit  = r_hit;
        o_stat.scan_end  = !r_hit && !r_sc_pend && (r_sc_raddr == WC_W'(NWORDS));
        o_stat.mark_last = (r_mk_addr == r_mk_last);
    end

    assign o_status        = r_status;
    assign o_first_block   = r_first_block;
    assign o_first_address = r_first_address;
    assign o_block_used    = r_block_used;

endmodule

// File: design/contiguous_block_bitmap_allocator.sv
// First-fit contiguous block allocator over a 1024-bit used/free bitmap; one item at a time.
// The bitmap is held as 64 rows of 16 bits; allocate scans the rows in order until a fit ends
// or the rows run out, then allocate and free read and rewrite each touched row in turn.
// The next item can be taken in the cycle after its result is loaded; a waiting result holds it off.
// Reset (synchronous, active low) frees all blocks at once via per-row valid bits, base zero.
module contiguous_block_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbba_req_if.sink    i_req,
    cbba_rsp_if.source  o_rsp,
    cbba_cfg_if.sink    i_cfg
);
    import cbba_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;

    // Handshake wiring; configuration writes are always taken.
    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    // Sequencer.
    cbba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Bitmap, block arithmetic and result registers.
    cbba_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_action          (i_req.action),
        .i_byte_size       (i_req.byte_size),
        .i_release_address (i_req.release_address),
        .i_block_index     (i_req.block_index),
        .o_status          (o_rsp.status),
        .o_first_block     (o_rsp.first_block),
        .o_first_address   (o_rsp.first_address),
        .o_block_used      (o_rsp.block_used)
    );

endmodule

// File: dv/contiguous_block_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit contiguous block allocator.
// Depends on cbba_pkg, the channel interfaces in cbba_ifs.sv and the allocator top level.
module contiguous_block_bitmap_allocator_tb;
    import cbba_pkg::*;

    // Spare action code, which the block must ignore.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RUN_LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES    = 300;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int MAX_REPORTS      = 40;
    localparam int RANDOM_PER_PHASE = 470;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SIZE_W-1:0] byte_size;
        logic [ADDR_W-1:0] release_address;
        logic [IDX_W-1:0]  block_index;
    } t_alloc_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FB_W-1:0]   first_block;
        logic [ADDR_W-1:0] first_address;
        logic              block_used;
    } t_alloc_rsp;

    // A run that the predictor saw allocated, kept so that it can be released later.
    typedef struct {
        int unsigned       first_blk;
        logic [SIZE_W-1:0] byte_size;
    } t_live_run;

    logic i_clk;
    logic i_rst_n;

    cbba_req_if req_if ();
    cbba_rsp_if rsp_if ();
    cbba_cfg_if cfg_if ();

    contiguous_block_bitmap_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: a private copy of the used/free map and of the region base.
    bit                block_map_model [TOTAL_BLOCK_COUNT];
    logic [CFG_W-1:0]  region_base_model;

    t_alloc_rsp  expected_rsps [$];
    t_live_run   live_runs [$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int error_count;
    int items_sent;
    int results_checked;
    int no_space_seen;
    int range_seen;
    int cfg_writes;
    int cycle_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: ends the simulation if traffic stops flowing.
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // Works out the response to one request and applies its effect on the map.
    function automatic t_alloc_rsp predict_response(input t_alloc_req rq);
        t_alloc_rsp      r;
        longint unsigned blocks;
        longint unsigned run_len;
        longint unsigned start;
        bit              found;
        r       = '0;
        blocks  = rq.byte_size;
        blocks  = (blocks + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK;
        run_len = 0;
        start   = 0;
        found   = 1'b0;
        case (rq.action)
            ACT_ALLOC: begin
                if (blocks == 0) begin
                    r.first_address = ADDR_W'(region_base_model);
                end else begin
                    if (blocks <= TOTAL_BLOCK_COUNT) begin
                        for (int i = 0; i < TOTAL_BLOCK_COUNT && !found; i++) begin
                            if (block_map_model[i]) begin
                                run_len = 0;
                            end else begin
                                run_len++;
                                if (run_len == blocks) begin
                                    found = 1'b1;
                                    start = i + 1 - blocks;
                                end
                            end
                        end
                    end
                    if (found) begin
                        for (longint unsigned j = 0; j < blocks; j++)
                            block_map_model[start + j] = 1'b1;
                        r.first_block   = FB_W'(start);
                        r.first_address = ADDR_W'(region_base_model + start * BYTES_PER_BLOCK);
                    end else begin
                        r.status = ST_NO_SPACE;
                    end
                end
            end
            ACT_FREE: begin
                if (rq.release_address < region_base_model) begin
                    r.status = ST_RANGE;
                end else begin
                    start = (rq.release_address - region_base_model) / BYTES_PER_BLOCK;
                    if (start + blocks > TOTAL_BLOCK_COUNT) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (longint unsigned j = 0; j < blocks; j++)
                            block_map_model[start + j] = 1'b0;
                    end
                end
            end
            ACT_QUERY: begin
                if (rq.block_index < TOTAL_BLOCK_COUNT)
                    r.block_used = block_map_model[rq.block_index];
                else
                    r.status = ST_RANGE;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_alloc_req make_req(input longint unsigned act,
                                            input longint unsigned sz,
                                            input longint unsigned ad,
                                            input longint unsigned ix);
        t_alloc_req rq;
        rq.action          = ACT_W'(act);
        rq.byte_size       = SIZE_W'(sz);
        rq.release_address = ADDR_W'(ad);
        rq.block_index     = IDX_W'(ix);
        return rq;
    endfunction

    // Offers one request and records its predicted response once it is accepted.
    task automatic send_request(input t_alloc_req rq);
        t_alloc_rsp pr;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
        end
        @(negedge i_clk);
        req_if.valid           = 1'b1;
        req_if.action          = rq.action;
        req_if.byte_size       = rq.byte_size;
        req_if.release_address = rq.release_address;
        req_if.block_index     = rq.block_index;
        do @(posedge i_clk); while (!req_if.ready);
        pr = predict_response(rq);
        expected_rsps.push_back(pr);
        items_sent++;
        if (rq.action == ACT_ALLOC && pr.status == ST_DONE && rq.byte_size != 0)
            live_runs.push_back('{pr.first_block, rq.byte_size});
    endtask

    // Stops offering requests and waits until every expected response has come back.
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the region base through the configuration channel while the block is idle.
    task automatic write_region_base(input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        region_base_model = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // One random request: mostly allocations and releases of live runs, plus queries and noise.
    task automatic send_random_item();
        t_alloc_req rq;
        t_live_run  lr;
        int         pick;
        int         free_share;
        int         k;
        int         sz_pick;
        rq.action          = ACT_ALLOC;
        rq.byte_size       = SIZE_W'($urandom);
        rq.release_address = ADDR_W'($urandom);
        rq.block_index     = IDX_W'($urandom);
        free_share = (live_runs.size() > 40) ? 60 : 30;
        pick       = $urandom_range(99);
        if (pick < 10) begin
            rq.action = ACT_W'($urandom_range(3));
        end else if (pick < 10 + free_share && live_runs.size() > 0) begin
            k  = $urandom_range(live_runs.size() - 1);
            lr = live_runs[k];
            live_runs.delete(k);
            rq.action          = ACT_FREE;
            rq.release_address = ADDR_W'(region_base_model + lr.first_blk * BYTES_PER_BLOCK
                + (($urandom_range(3) == 0) ? $urandom_range(BYTES_PER_BLOCK - 1) : 0));
            rq.byte_size = ($urandom_range(7) == 0) ? SIZE_W'($urandom_range(lr.byte_size))
                                                    : lr.byte_size;
        end else if (pick < 75) begin
            sz_pick = $urandom_range(99);
            if (sz_pick < 5)
                rq.byte_size = '0;
            else if (sz_pick < 70)
                rq.byte_size = SIZE_W'($urandom_range(8 * BYTES_PER_BLOCK, 1));
            else if (sz_pick < 92)
                rq.byte_size = SIZE_W'($urandom_range(64 * BYTES_PER_BLOCK, 1));
            else if (sz_pick < 97)
                rq.byte_size = SIZE_W'($urandom_range(TOTAL_BLOCK_COUNT * BYTES_PER_BLOCK, 1));
        end else begin
            rq.action = ACT_QUERY;
            if ($urandom_range(1) == 0)
                rq.block_index = IDX_W'($urandom_range(127));
        end
        send_request(rq);
    endtask

    // Response channel: random stalls, plus a long hold-off when one is requested.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
    endtask

    // Compares each response transaction with the oldest expected response.
    always @(posedge i_clk) begin
        t_alloc_rsp ex;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: response with none expected, status 0x%0h",
                             $time, rsp_if.status);
            end else begin
                ex = expected_rsps.pop_front();
                results_checked++;
                if (ex.status == ST_NO_SPACE)
                    no_space_seen++;
                if (ex.status == ST_RANGE)
                    range_seen++;
                if (rsp_if.status !== ex.status)
                    report_mismatch("status", ex.status, rsp_if.status);
                if (rsp_if.first_block !== ex.first_block)
                    report_mismatch("first_block", ex.first_block, rsp_if.first_block);
                if (rsp_if.first_address !== ex.first_address)
                    report_mismatch("first_address", ex.first_address, rsp_if.first_address);
                if (rsp_if.block_used !== ex.block_used)
                    report_mismatch("block_used", ex.block_used, rsp_if.block_used);
            end
        end
    end

    // Edge sizes, first fit into a hole, a full map and the rejected releases.
    task automatic test_directed_alloc_free();
        send_request(make_req(ACT_QUERY, 0, 0, 0));
        send_request(make_req(ACT_ALLOC, 0, 0, 0));
        send_request(make_req(ACT_ALLOC, 1, 0, 0));
        send_request(make_req(ACT_ALLOC, 513, 0, 0));
        send_request(make_req(ACT_ALLOC, 512, 0, 0));
        send_request(make_req(ACT_QUERY, 0, 0, 2));
        send_request(make_req(ACT_FREE, 1024, 512, 0));
        send_request(make_req(ACT_ALLOC, 600, 0, 0));
        send_request(make_req(ACT_ALLOC, '1, 0, 0));
        send_request(make_req(ACT_ALLOC, 1020 * 512, 0, 0));
        send_request(make_req(ACT_ALLOC, 1, 0, 0));
        send_request(make_req(ACT_QUERY, 0, 0, '1));
        send_request(make_req(ACT_FREE, 0, 0, 0));
        send_request(make_req(ACT_FREE, 512, 1023 * 512, 0));
        send_request(make_req(ACT_FREE, 1024, 1023 * 512, 0));
        send_request(make_req(ACT_FREE, 0, '1, 0));
        send_request(make_req(ACT_FREE, 1, 5 * 512 + 77, 0));
        send_request(make_req(ACT_UNUSED, '1, '1, '1));
        send_request(make_req(ACT_FREE, '1, 0, 0));
        send_request(make_req(ACT_FREE, 1024 * 512, 0, 0));
        send_request(make_req(ACT_ALLOC, 1024 * 512, 0, 0));
        send_request(make_req(ACT_FREE, 1024 * 512, 0, 0));
    endtask

    // Addresses relative to a non-zero region base, including the largest one.
    task automatic test_region_base_offset();
        write_region_base(24'h001000);
        send_request(make_req(ACT_FREE, 512, 25'h0000FFF, 0));
        send_request(make_req(ACT_ALLOC, 1, 0, 0));
        write_region_base('1);
        send_request(make_req(ACT_ALLOC, 512, 0, 0));
        send_request(make_req(ACT_FREE, 1024, 25'h0FFFFFF, 0));
    endtask

    // Receiver holds off for a long stretch while requests keep being offered.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (16) send_random_item();
    endtask

    // One phase of random traffic under a given region base and idling pattern.
    task automatic test_random_traffic(input logic [CFG_W-1:0] start_value,
                                       input int idle_share, input int stall_share);
        write_region_base(start_value);
        idle_pct  = idle_share;
        stall_pct = stall_share;
        repeat (RANDOM_PER_PHASE) send_random_item();
    endtask

    initial begin
        req_if.valid           = 1'b0;
        req_if.action          = ACT_ALLOC;
        req_if.byte_size       = '0;
        req_if.release_address = '0;
        req_if.block_index     = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.data            = '0;
        i_rst_n                = 1'b0;
        idle_pct               = 0;
        stall_pct              = 0;
        hold_left              = 0;
        error_count            = 0;
        items_sent             = 0;
        results_checked        = 0;
        no_space_seen          = 0;
        range_seen             = 0;
        cfg_writes             = 0;
        region_base_model      = '0;
        foreach (block_map_model[i])
            block_map_model[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_alloc_free();
        test_region_base_offset();
        test_backpressure();
        test_random_traffic('0, 0, 0);
        test_random_traffic(24'(($urandom & 24'hFFFFFF) & ~24'h1FF), 77, 0);
        test_random_traffic(24'($urandom), 0, 77);
        test_random_traffic('1, 21, 21);

        stall_pct = 0;
        idle_pct  = 0;
        drain_results();

        $display("Covered %0d requests and %0d responses over %0d base address writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Responses included %0d without space and %0d out of range.",
                 no_space_seen, range_seen);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: contiguous_block_bitmap_allocator.f
+incdir+design
design/cbba_pkg.sv
design/cbba_ifs.sv
design/cbba_ctrl.sv
design/cbba_datapath.sv
design/contiguous_block_bitmap_allocator.sv
dv/contiguous_block_bitmap_allocator_tb.sv
